@@ design/isl_pkg.sv @@
// Shared constants, codes and cell control type for the indexed shift list.
package isl_pkg;

  localparam int CAPACITY     = 64;
  localparam int ELEMENT_BITS = 32;

  localparam int FUNC_W  = 4;
  localparam int INDEX_W = 6;
  localparam int VALUE_W = 32;
  localparam int ELEM_W  = 32;
  localparam int LEN_W   = 7;
  localparam int STAT_W  = 2;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > INDEX_W + 1) ? CNT_W : INDEX_W + 1;

  typedef enum logic [FUNC_W-1:0] {
    FN_READ       = 4'd0,
    FN_WRITE      = 4'd1,
    FN_INSERT     = 4'd2,
    FN_REMOVE     = 4'd3,
    FN_PUSH_BACK  = 4'd4,
    FN_POP_BACK   = 4'd5,
    FN_PUSH_FRONT = 4'd6,
    FN_POP_FRONT  = 4'd7,
    FN_FRONT      = 4'd8,
    FN_BACK       = 4'd9,
    FN_CLEAR      = 4'd10
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CO_HOLD   = 2'd0,
    CO_LOAD   = 2'd1,
    CO_INSERT = 2'd2,
    CO_REMOVE = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e                op;
    logic [IDX_W-1:0]        pos;
    logic [IDX_W-1:0]        rd_pos;
    logic [ELEMENT_BITS-1:0] value;
  } cell_ctl_t;

endpackage

@@ design/isl_cell.sv @@
// One list slot: holds an entry, shifts with its neighbors, drives the read bus.
module isl_cell (
  input  logic                          clk_i,
  input  logic [isl_pkg::IDX_W-1:0]     my_idx_i,
  input  isl_pkg::cell_ctl_t            ctl_i,
  input  logic [isl_pkg::ELEMENT_BITS-1:0] left_i,
  input  logic [isl_pkg::ELEMENT_BITS-1:0] right_i,
  output logic [isl_pkg::ELEMENT_BITS-1:0] data_o,
  output logic [isl_pkg::ELEMENT_BITS-1:0] rd_o
);
  import isl_pkg::*;

  logic [ELEMENT_BITS-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      CO_LOAD: begin
        if (my_idx_i == ctl_i.pos) data_d = ctl_i.value;
      end
      CO_INSERT: begin
        if (my_idx_i == ctl_i.pos) data_d = ctl_i.value;
        else if (my_idx_i > ctl_i.pos) data_d = left_i;
      end
      CO_REMOVE: begin
        if (my_idx_i >= ctl_i.pos) data_d = right_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (my_idx_i == ctl_i.rd_pos) ? data_q : '0;

endmodule

@@ design/isl_ctrl.sv @@
// Request decode, entry count, status and result word registers.
module isl_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [isl_pkg::FUNC_W-1:0]       func_i,
  input  logic [isl_pkg::INDEX_W-1:0]      index_i,
  input  logic [isl_pkg::VALUE_W-1:0]      value_i,
  input  logic [isl_pkg::ELEMENT_BITS-1:0] rd_data_i,
  output isl_pkg::cell_ctl_t               ctl_o,
  output logic                             done_o,
  output logic [isl_pkg::ELEM_W-1:0]       element_o,
  output logic [isl_pkg::LEN_W-1:0]        length_o,
  output logic                             is_empty_o,
  output logic [isl_pkg::STAT_W-1:0]       status_o
);
  import isl_pkg::*;

  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    done_q;
  logic [ELEM_W-1:0]       elem_q, elem_d;
  status_e                 stat_q, stat_d;
  logic                    take;
  logic                    ok_rd, ok_ins, full, empty;
  logic [IDX_W-1:0]        idx, last;

  assign ok_rd  = CMP_W'(index_i) <  CMP_W'(cnt_q);
  assign ok_ins = CMP_W'(index_i) <= CMP_W'(cnt_q);
  assign full   = cnt_q == CNT_W'(CAPACITY);
  assign empty  = cnt_q == '0;
  assign idx    = IDX_W'(index_i);
  assign last   = IDX_W'(cnt_q - 1'b1);

  always_comb begin
    ctl_o.op     = CO_HOLD;
    ctl_o.pos    = idx;
    ctl_o.rd_pos = idx;
    ctl_o.value  = ELEMENT_BITS'(value_i);
    cnt_d        = cnt_q;
    stat_d       = ST_OK;
    take         = 1'b0;
    case (func_e'(func_i))
      FN_READ: begin
        if (ok_rd) take = 1'b1;
        else stat_d = ST_RANGE;
      end
      FN_WRITE: begin
        if (ok_rd) ctl_o.op = CO_LOAD;
        else stat_d = ST_RANGE;
      end
      FN_INSERT: begin
        if (!ok_ins) stat_d = ST_RANGE;
        else if (full) stat_d = ST_FULL;
        else begin
          ctl_o.op = CO_INSERT;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      FN_REMOVE: begin
        if (empty) stat_d = ST_EMPTY;
        else if (!ok_rd) stat_d = ST_RANGE;
        else begin
          ctl_o.op = CO_REMOVE;
          take     = 1'b1;
          cnt_d    = cnt_q - 1'b1;
        end
      end
      FN_PUSH_BACK: begin
        if (full) stat_d = ST_FULL;
        else begin
          ctl_o.op  = CO_INSERT;
          ctl_o.pos = IDX_W'(cnt_q);
          cnt_d     = cnt_q + 1'b1;
        end
      end
      FN_POP_BACK: begin
        if (empty) stat_d = ST_EMPTY;
        else begin
          ctl_o.op     = CO_REMOVE;
          ctl_o.pos    = last;
          ctl_o.rd_pos = last;
          take         = 1'b1;
          cnt_d        = cnt_q - 1'b1;
        end
      end
      FN_PUSH_FRONT: begin
        if (full) stat_d = ST_FULL;
        else begin
          ctl_o.op  = CO_INSERT;
          ctl_o.pos = '0;
          cnt_d     = cnt_q + 1'b1;
        end
      end
      FN_POP_FRONT: begin
        if (empty) stat_d = ST_EMPTY;
        else begin
          ctl_o.op     = CO_REMOVE;
          ctl_o.pos    = '0;
          ctl_o.rd_pos = '0;
          take         = 1'b1;
          cnt_d        = cnt_q - 1'b1;
        end
      end
      FN_FRONT: begin
        ctl_o.rd_pos = '0;
        if (empty) stat_d = ST_EMPTY;
        else take = 1'b1;
      end
      FN_BACK: begin
        ctl_o.rd_pos = last;
        if (empty) stat_d = ST_EMPTY;
        else take = 1'b1;
      end
      FN_CLEAR: cnt_d = '0;
      default: ;
    endcase
    if (!start_i) begin
      ctl_o.op = CO_HOLD;
      cnt_d    = cnt_q;
    end
    elem_d = take ? ELEM_W'(rd_data_i) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      elem_q <= elem_d;
      stat_q <= stat_d;
    end
  end

  assign done_o     = done_q;
  assign element_o  = elem_q;
  assign length_o   = LEN_W'(cnt_q);
  assign is_empty_o = cnt_q == '0;
  assign status_o   = stat_q;

endmodule

@@ design/indexed_shift_list.sv @@
// Indexed shift list: ordered list of handles held in a chain of shifting cells.
// The result word is registered and strobed on done_o in the cycle after start_i is taken.
// Throughput: one request word per cycle; busy_o stays low, every cell shifts at once.
// Reset: entry count cleared, no result pending; slot contents undefined until written.
// The receiver cannot stall; each result is valid only in its done_o cycle.
module indexed_shift_list (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [isl_pkg::FUNC_W-1:0]  func_i,
  input  logic [isl_pkg::INDEX_W-1:0] index_i,
  input  logic [isl_pkg::VALUE_W-1:0] value_i,
  output logic                        done_o,
  output logic [isl_pkg::ELEM_W-1:0]  element_o,
  output logic [isl_pkg::LEN_W-1:0]   length_o,
  output logic                        is_empty_o,
  output logic [isl_pkg::STAT_W-1:0]  status_o
);
  import isl_pkg::*;

  cell_ctl_t               ctl;
  logic [ELEMENT_BITS-1:0] slot [CAPACITY];
  logic [ELEMENT_BITS-1:0] rd   [CAPACITY];
  logic [ELEMENT_BITS-1:0] rd_bus;

  assign busy_o = 1'b0;

  isl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .func_i     (func_i),
    .index_i    (index_i),
    .value_i    (value_i),
    .rd_data_i  (rd_bus),
    .ctl_o      (ctl),
    .done_o     (done_o),
    .element_o  (element_o),
    .length_o   (length_o),
    .is_empty_o (is_empty_o),
    .status_o   (status_o)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEMENT_BITS-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = ctl.value;
    end else begin : g_mid
      assign left = slot[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = slot[i];
    end else begin : g_inner
      assign right = slot[i+1];
    end
    isl_cell u_cell (
      .clk_i    (clk_i),
      .my_idx_i (IDX_W'(i)),
      .ctl_i    (ctl),
      .left_i   (left),
      .right_i  (right),
      .data_o   (slot[i]),
      .rd_o     (rd[i])
    );
  end

  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_bus = rd_bus | rd[k];
    end
  end

endmodule

@@ verif/tb_indexed_shift_list.sv @@
// Self-checking testbench for indexed_shift_list: queued request words, in-order result check.
`timescale 1ns / 100ps

module tb_indexed_shift_list;
  import isl_pkg::*;

  localparam logic [FUNC_W-1:0] FN_SPARE_MIN = FUNC_W'(FN_CLEAR + 1);
  localparam logic [FUNC_W-1:0] FN_SPARE_MAX = '1;
  localparam int RAND_WORDS     = 1700;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
    bit                 hold;
  } req_t;

  typedef struct {
    logic [ELEM_W-1:0] element;
    logic [LEN_W-1:0]  length;
    logic              is_empty;
    status_e           status;
  } rsp_t;

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               start_i = 1'b0;
  logic [FUNC_W-1:0]  func_i  = '0;
  logic [INDEX_W-1:0] index_i = '0;
  logic [VALUE_W-1:0] value_i = '0;
  logic               busy_o;
  logic               done_o;
  logic [ELEM_W-1:0]  element_o;
  logic [LEN_W-1:0]   length_o;
  logic               is_empty_o;
  logic [STAT_W-1:0]  status_o;

  indexed_shift_list dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .func_i     (func_i),
    .index_i    (index_i),
    .value_i    (value_i),
    .done_o     (done_o),
    .element_o  (element_o),
    .length_o   (length_o),
    .is_empty_o (is_empty_o),
    .status_o   (status_o)
  );

  always #10 clk_i = ~clk_i;

  // list shadow: copy 0 plans the stimulus, copy 1 tracks accepted words
  logic [ELEMENT_BITS-1:0] slot_mem [2][CAPACITY];
  int unsigned             fill [2] = '{0, 0};

  req_t pend_q[$];
  rsp_t want_q[$];
  int   n_acc   = 0;
  int   n_seen  = 0;
  int   err_cnt = 0;
  int   n_rand  = 0;
  int   peak_len = 0;
  int   stat_cnt [4] = '{0, 0, 0, 0};

  function automatic void list_put(input int s, input int unsigned pos,
                                   input logic [VALUE_W-1:0] v);
    for (int i = fill[s]; i > pos; i--)
      slot_mem[s][i] = slot_mem[s][i-1];
    slot_mem[s][pos] = v[ELEMENT_BITS-1:0];
    fill[s]++;
  endfunction

  function automatic logic [ELEMENT_BITS-1:0] list_take(input int s, input int unsigned pos);
    logic [ELEMENT_BITS-1:0] v;
    v = slot_mem[s][pos];
    for (int i = pos; i + 1 < fill[s]; i++)
      slot_mem[s][i] = slot_mem[s][i+1];
    fill[s]--;
    return v;
  endfunction

  function automatic rsp_t list_apply(input int s, input req_t r);
    rsp_t        p;
    int unsigned n;
    bit          full, empty;
    p.element = '0;
    p.status  = ST_OK;
    n     = fill[s];
    full  = (n >= CAPACITY);
    empty = (n == 0);
    case (r.func)
      FN_READ: begin
        if (r.index < n) p.element = slot_mem[s][r.index];
        else p.status = ST_RANGE;
      end
      FN_WRITE: begin
        if (r.index < n) slot_mem[s][r.index] = r.value[ELEMENT_BITS-1:0];
        else p.status = ST_RANGE;
      end
      FN_INSERT: begin
        if (r.index > n) p.status = ST_RANGE;
        else if (full) p.status = ST_FULL;
        else list_put(s, r.index, r.value);
      end
      FN_REMOVE: begin
        if (empty) p.status = ST_EMPTY;
        else if (r.index >= n) p.status = ST_RANGE;
        else p.element = list_take(s, r.index);
      end
      FN_PUSH_BACK: begin
        if (full) p.status = ST_FULL;
        else list_put(s, n, r.value);
      end
      FN_POP_BACK: begin
        if (empty) p.status = ST_EMPTY;
        else p.element = list_take(s, n - 1);
      end
      FN_PUSH_FRONT: begin
        if (full) p.status = ST_FULL;
        else list_put(s, 0, r.value);
      end
      FN_POP_FRONT: begin
        if (empty) p.status = ST_EMPTY;
        else p.element = list_take(s, 0);
      end
      FN_FRONT: begin
        if (empty) p.status = ST_EMPTY;
        else p.element = slot_mem[s][0];
      end
      FN_BACK: begin
        if (empty) p.status = ST_EMPTY;
        else p.element = slot_mem[s][n-1];
      end
      FN_CLEAR: begin
        fill[s] = 0;
      end
      default: ;
    endcase
    p.length   = LEN_W'(fill[s]);
    p.is_empty = (fill[s] == 0);
    return p;
  endfunction

  function automatic void plan(input logic [FUNC_W-1:0] f, input logic [INDEX_W-1:0] idx,
                               input logic [VALUE_W-1:0] v, input bit hold);
    req_t r;
    r = '{func: f, index: idx, value: v, hold: hold};
    void'(list_apply(0, r));
    pend_q = {pend_q, r};
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index(input bit for_insert);
    int unsigned n;
    n = fill[0];
    if ($urandom_range(0, 9) == 0) return INDEX_W'($urandom_range(0, 63));
    if (for_insert) return INDEX_W'((n > 63) ? $urandom_range(0, 63) : $urandom_range(0, n));
    return (n == 0) ? '0 : INDEX_W'($urandom_range(0, n - 1));
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func(input int phase);
    int r;
    r = $urandom_range(0, 99);
    if (phase == 9) return ($urandom_range(0, 3) == 0) ?
                           FUNC_W'($urandom_range(FN_SPARE_MIN, FN_SPARE_MAX)) :
                           FUNC_W'($urandom_range(FN_READ, FN_CLEAR));
    if (r == 0) return FN_CLEAR;
    if (phase <= 3) begin
      if (r < 40) return FN_PUSH_BACK;
      if (r < 55) return FN_PUSH_FRONT;
      if (r < 75) return FN_INSERT;
      if (r < 80) return FN_READ;
      if (r < 85) return FN_WRITE;
      if (r < 90) return FN_REMOVE;
      if (r < 95) return ($urandom_range(0, 1) != 0) ? FN_POP_BACK : FN_POP_FRONT;
      return ($urandom_range(0, 1) != 0) ? FN_FRONT : FN_BACK;
    end
    if (phase <= 6) begin
      if (r < 30) return FN_POP_BACK;
      if (r < 50) return FN_POP_FRONT;
      if (r < 75) return FN_REMOVE;
      if (r < 85) return ($urandom_range(0, 1) != 0) ? FN_PUSH_BACK : FN_INSERT;
      if (r < 92) return FN_READ;
      return ($urandom_range(0, 1) != 0) ? FN_FRONT : FN_BACK;
    end
    if (r < 35) return FN_READ;
    if (r < 60) return FN_WRITE;
    if (r < 70) return FN_FRONT;
    if (r < 80) return FN_BACK;
    if (r < 85) return FN_INSERT;
    if (r < 90) return FN_REMOVE;
    return FUNC_W'($urandom_range(FN_PUSH_BACK, FN_POP_FRONT));
  endfunction

  initial begin : stim
    int                 phase, run_len;
    logic [FUNC_W-1:0]  f;
    logic [VALUE_W-1:0] v;
    // empty-list errors, range errors, every operation, value and index extremes
    plan(FN_POP_BACK,   '0, '0, 1'b0);
    plan(FN_POP_FRONT,  '0, '0, 1'b0);
    plan(FN_FRONT,      '0, '0, 1'b0);
    plan(FN_BACK,       '0, '0, 1'b0);
    plan(FN_REMOVE,     '0, '0, 1'b0);
    plan(FN_READ,       '0, '0, 1'b0);
    plan(FN_WRITE,      '1, '1, 1'b0);
    plan(FN_INSERT,     6'd1, 32'h1234_5678, 1'b0);
    plan(FN_INSERT,     '0, '0, 1'b0);
    plan(FN_PUSH_BACK,  '0, '1, 1'b0);
    plan(FN_PUSH_FRONT, '1, 32'hA5A5_A5A5, 1'b0);
    plan(FN_READ,       6'd2, '0, 1'b0);
    plan(FN_WRITE,      6'd1, 32'h5A5A_5A5A, 1'b0);
    plan(FN_INSERT,     6'd3, 32'h0000_0001, 1'b0);
    plan(FN_REMOVE,     6'd4, '0, 1'b0);
    plan(FN_REMOVE,     6'd1, '0, 1'b0);
    plan(FN_FRONT,      '1, '0, 1'b0);
    plan(FN_BACK,       '0, '0, 1'b0);
    plan(FN_SPARE_MAX,  '1, '1, 1'b0);
    plan(FN_SPARE_MIN,  '0, '0, 1'b0);
    plan(FN_POP_BACK,   '0, '0, 1'b0);
    plan(FN_POP_FRONT,  '0, '0, 1'b0);
    plan(FN_CLEAR,      '0, '0, 1'b0);
    plan(FN_READ,       '0, '0, 1'b0);

    while (n_rand < RAND_WORDS) begin
      phase   = $urandom_range(0, 9);
      run_len = (phase == 9) ? $urandom_range(5, 20) : $urandom_range(20, 130);
      repeat (run_len) begin
        f = pick_func(phase);
        v = ($urandom_range(0, 15) == 0) ? (($urandom_range(0, 1) != 0) ? '1 : '0) : $urandom();
        plan(f, pick_index(f == FN_INSERT), v, (n_rand == 1) || ($urandom_range(0, 199) == 0));
        if (f <= FN_CLEAR) n_rand++;
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pend_q.size() != 0 || start_i || want_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("%0d request words accepted, %0d result words checked, peak length %0d",
             n_acc, n_seen, peak_len);
    $display("status seen: ok %0d, range %0d, full %0d, empty %0d",
             stat_cnt[ST_OK], stat_cnt[ST_RANGE], stat_cnt[ST_FULL], stat_cnt[ST_EMPTY]);
    if (err_cnt == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // driver: bursts of random length with random gaps
  always @(posedge clk_i or negedge rst_ni) begin : drv
    req_t cur;
    rsp_t nxt;
    int   burst_left;
    int   gap_left;
    if (!rst_ni) begin
      start_i    <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!start_i || !busy_o) begin
      if (start_i) begin
        nxt    = list_apply(1, cur);
        want_q = {want_q, nxt};
        n_acc++;
      end
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (pend_q.size() != 0 && !(pend_q[0].hold && n_acc != n_seen)) begin
        cur = pend_q[0];
        pend_q.delete(0);
        func_i  <= cur.func;
        index_i <= cur.index;
        value_i <= cur.value;
        start_i <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i or negedge rst_ni) begin : mon
    rsp_t want;
    int   idle_cyc;
    if (!rst_ni) begin
      n_seen   <= 0;
      idle_cyc = 0;
    end else begin
      if (done_o) begin
        n_seen <= n_seen + 1;
        if (want_q.size() == 0) begin
          $error("result word with nothing expected");
          err_cnt++;
        end else begin
          want = want_q[0];
          want_q.delete(0);
          stat_cnt[want.status]++;
          if (want.length > peak_len) peak_len = want.length;
          if (element_o !== want.element) begin
            $error("element: expected %h, got %h", want.element, element_o);
            err_cnt++;
          end
          if (length_o !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, length_o);
            err_cnt++;
          end
          if (is_empty_o !== want.is_empty) begin
            $error("is_empty: expected %b, got %b", want.is_empty, is_empty_o);
            err_cnt++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            err_cnt++;
          end
        end
      end
      if (done_o || (start_i && !busy_o)) begin
        idle_cyc = 0;
      end else if (idle_cyc >= WATCHDOG_LIMIT) begin
        $display("watchdog: no activity for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cyc++;
      end
    end
  end

endmodule

@@ filelist.f @@
design/isl_pkg.sv
design/isl_cell.sv
design/isl_ctrl.sv
design/indexed_shift_list.sv
verif/tb_indexed_shift_list.sv
